FILE: rtl/core/rlpws_pkg.sv
// Shared types, constants and the colour byte reorder function for the
// pulse-width LED serializer. No dependencies.
`timescale 1ns / 1ps

package rlpws_pkg;

  localparam int FRAME_BITS      = 24;
  localparam int BITS_LEFT_W     = 5;
  localparam int COUNT_WIDTH_DEF = 8;
  localparam int CFG_IDX_W       = 3;

  localparam logic [2:0] ORDER_RST     = 3'd5;
  localparam logic [7:0] ONE_HIGH_RST  = 8'd13;
  localparam logic [7:0] ONE_LOW_RST   = 8'd7;
  localparam logic [7:0] ZERO_HIGH_RST = 8'd6;
  localparam logic [7:0] ZERO_LOW_RST  = 8'd14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_ORDER = 3'd0,
    REG_ONE_HIGH    = 3'd1,
    REG_ONE_LOW     = 3'd2,
    REG_ZERO_HIGH   = 3'd3,
    REG_ZERO_LOW    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ORDER_RGB = 3'd0,
    ORDER_BGR = 3'd1,
    ORDER_BRG = 3'd2,
    ORDER_RBG = 3'd3,
    ORDER_GBR = 3'd4,
    ORDER_GRB = 3'd5
  } color_order_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HIGH = 3'b010,
    PH_LOW  = 3'b100
  } phase_t;

  typedef struct packed {
    logic                   found;
    logic [FRAME_BITS-1:0]  shift_bits;
    logic [BITS_LEFT_W-1:0] bits_left;
  } seek_res_t;

  function automatic logic [FRAME_BITS-1:0] reorder(input logic [2:0] order,
                                                     input logic [FRAME_BITS-1:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [FRAME_BITS-1:0] res;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    unique case (order)
      ORDER_RGB: res = {r, g, b};
      ORDER_BGR: res = {b, g, r};
      ORDER_BRG: res = {b, r, g};
      ORDER_RBG: res = {r, b, g};
      ORDER_GBR: res = {g, b, r};
      default:   res = {g, r, b};
    endcase
    return res;
  endfunction

endpackage

FILE: rtl/core/rlpws_bit_seek.sv
// Finds the next remaining frame bit that has a non-empty pulse and aligns it
// to the top of the shift word. Depends on rlpws_pkg.
`timescale 1ns / 1ps

module rlpws_bit_seek
  import rlpws_pkg::*;
(
  input  logic [FRAME_BITS-1:0]  shift_bits,
  input  logic [BITS_LEFT_W-1:0] bits_left,
  input  logic                   live_one,
  input  logic                   live_zero,
  output seek_res_t              res
);

  logic [FRAME_BITS-1:0]  live;
  logic [BITS_LEFT_W-1:0] idx;

  always_comb begin
    for (int k = 0; k < FRAME_BITS; k++) begin
      live[k] = (BITS_LEFT_W'(k) < bits_left) &&
                (shift_bits[FRAME_BITS-1-k] ? live_one : live_zero);
    end
  end

  // lowest set position wins
  always_comb begin
    idx = '0;
    for (int k = FRAME_BITS - 1; k >= 0; k--) begin
      if (live[k]) begin
        idx = BITS_LEFT_W'(k);
      end
    end
  end

  assign res.found      = |live;
  assign res.shift_bits = shift_bits << idx;
  assign res.bits_left  = bits_left - idx;

endmodule

FILE: rtl/core/rgb_led_pulse_width_serializer.sv
// Top level of the pulse-width LED serializer: input stage, frame state,
// configuration registers and result register. Depends on rlpws_pkg, rlpws_bit_seek.
`timescale 1ns / 1ps

// Each input transaction is either a colour load (tuser 0) or one line tick
// (tuser 1) and yields exactly one result transaction carrying the line level,
// busy, frame-done and load-rejected flags. One transaction is taken per clock
// cycle while the output is not stalled: an input register and a result
// register bracket a single pass of logic.
// Bits whose high and low lengths are both zero are skipped on the same
// transaction by a 24-bit priority search. Phase lengths above the
// COUNT_WIDTH counter maximum saturate. A load while a frame is in progress is
// dropped and flagged. Configuration writes are taken at any time with
// cfg_ready held high and should be made while the block is idle.
module rgb_led_pulse_width_serializer
  import rlpws_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // [23:0] colour
  input  logic [0:0]           in_tuser,   // [0] cmd
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] line_level, [1] busy_res,
                                           // [2] frame_done, [3] load_rejected
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int LW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [LW-1:0] CAP = LW'((1 << COUNT_WIDTH) - 1);

  function automatic logic [COUNT_WIDTH-1:0] clamp_len(input logic [7:0] v);
    logic [LW-1:0] vx;
    vx = LW'(v);
    return (vx > CAP) ? COUNT_WIDTH'(CAP) : COUNT_WIDTH'(vx);
  endfunction

  // configuration
  logic [2:0] color_order_r;
  logic [7:0] one_high_r, one_low_r, zero_high_r, zero_low_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_order_r <= ORDER_RST;
      one_high_r    <= ONE_HIGH_RST;
      one_low_r     <= ONE_LOW_RST;
      zero_high_r   <= ZERO_HIGH_RST;
      zero_low_r    <= ZERO_LOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COLOR_ORDER: color_order_r <= cfg_data[2:0];
        REG_ONE_HIGH:    one_high_r    <= cfg_data;
        REG_ONE_LOW:     one_low_r     <= cfg_data;
        REG_ZERO_HIGH:   zero_high_r   <= cfg_data;
        REG_ZERO_LOW:    zero_low_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  logic        in_vld_r;
  logic        cmd_r;
  logic [23:0] color_r;
  logic        out_vld_r;
  logic [7:0]  out_data_r;
  logic        adv;
  logic        fire;

  assign adv       = !out_vld_r || out_tready;
  assign fire      = in_vld_r && adv;
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tuser[0];
      color_r <= in_tdata;
    end
  end

  // frame state
  phase_t                 phase_r, phase_nxt;
  logic [FRAME_BITS-1:0]  shift_r, shift_nxt;
  logic [BITS_LEFT_W-1:0] left_r, left_nxt;
  logic [COUNT_WIDTH-1:0] ticks_r, ticks_nxt;

  logic [COUNT_WIDTH-1:0] oh_len, ol_len, zh_len, zl_len;
  logic                   live_one, live_zero;
  logic [FRAME_BITS-1:0]  seek_shift;
  logic [BITS_LEFT_W-1:0] seek_left;
  seek_res_t              seek;
  logic                   do_enter;
  logic [COUNT_WIDTH-1:0] ticks_dec;
  logic [COUNT_WIDTH-1:0] cur_low;
  logic [COUNT_WIDTH-1:0] ent_high;
  logic [COUNT_WIDTH-1:0] ent_low;
  logic                   level, done, rejected;

  assign oh_len    = clamp_len(one_high_r);
  assign ol_len    = clamp_len(one_low_r);
  assign zh_len    = clamp_len(zero_high_r);
  assign zl_len    = clamp_len(zero_low_r);
  assign live_one  = (oh_len != '0) || (ol_len != '0);
  assign live_zero = (zh_len != '0) || (zl_len != '0);

  always_comb begin
    if (!cmd_r) begin
      seek_shift = reorder(color_order_r, color_r);
      seek_left  = BITS_LEFT_W'(FRAME_BITS);
    end else begin
      seek_shift = shift_r << 1;
      seek_left  = (left_r != '0) ? left_r - BITS_LEFT_W'(1) : left_r;
    end
  end

  rlpws_bit_seek u_seek (
    .shift_bits (seek_shift),
    .bits_left  (seek_left),
    .live_one   (live_one),
    .live_zero  (live_zero),
    .res        (seek)
  );

  assign ticks_dec = (ticks_r != '0) ? ticks_r - COUNT_WIDTH'(1) : ticks_r;
  assign cur_low   = shift_r[FRAME_BITS-1] ? ol_len : zl_len;
  assign ent_high  = seek.shift_bits[FRAME_BITS-1] ? oh_len : zh_len;
  assign ent_low   = seek.shift_bits[FRAME_BITS-1] ? ol_len : zl_len;

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    left_nxt  = left_r;
    ticks_nxt = ticks_r;
    do_enter  = 1'b0;
    level     = (phase_r == PH_HIGH);
    rejected  = 1'b0;
    if (!cmd_r) begin
      if (phase_r != PH_IDLE) begin
        rejected = 1'b1;
      end else begin
        do_enter = 1'b1;
      end
    end else if (phase_r != PH_IDLE) begin
      ticks_nxt = ticks_dec;
      if (ticks_dec == '0) begin
        if (phase_r == PH_HIGH && cur_low != '0) begin
          phase_nxt = PH_LOW;
          ticks_nxt = cur_low;
        end else begin
          do_enter = 1'b1;
        end
      end
    end
    if (do_enter) begin
      if (seek.found) begin
        shift_nxt = seek.shift_bits;
        left_nxt  = seek.bits_left;
        if (ent_high != '0) begin
          phase_nxt = PH_HIGH;
          ticks_nxt = ent_high;
        end else begin
          phase_nxt = PH_LOW;
          ticks_nxt = ent_low;
        end
      end else begin
        phase_nxt = PH_IDLE;
        shift_nxt = '0;
        left_nxt  = '0;
        ticks_nxt = '0;
      end
    end
    done = do_enter && !seek.found;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      shift_r <= '0;
      left_r  <= '0;
      ticks_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      left_r  <= left_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {4'b0000, rejected, done, (phase_nxt != PH_IDLE), level};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: dv/testbench.sv
// Self-checking bench for rgb_led_pulse_width_serializer: colour loads and line ticks
// go in on a stream port, each result is checked against a cycle-free line model.
// Depends on rlpws_pkg and the serializer RTL only.
`timescale 1ns / 1ps

module testbench;
  import rlpws_pkg::*;

  localparam logic        CMD_LOAD        = 1'b0;
  localparam logic        CMD_TICK        = 1'b1;
  localparam logic [2:0]  UNUSED_REG      = 3'd7;
  localparam int          CNT_MAX         = (1 << COUNT_WIDTH_DEF) - 1;
  localparam int          NUM_SETTINGS    = 10;
  localparam int          ITEMS_PER_SET   = 30;
  localparam int          LONG_HOLD       = 400;
  localparam int          MAX_REPORTS     = 10;

  typedef struct packed {
    logic [3:0] pad;
    logic       load_rejected;
    logic       frame_done;
    logic       busy;
    logic       line_level;
  } led_result_t;

  class led_frame_scoreboard;
    logic [2:0]            order;
    logic [7:0]            one_hi, one_lo, zero_hi, zero_lo;
    logic [FRAME_BITS-1:0] shift_bits;
    logic [4:0]            bits_left;
    phase_t                ph;
    logic [7:0]            ticks_left;
    led_result_t           line_q[$];
    int unsigned           mismatches, loads, rejects, ticks, frames, settings;

    function new();
      order      = ORDER_RST;
      one_hi     = ONE_HIGH_RST;
      one_lo     = ONE_LOW_RST;
      zero_hi    = ZERO_HIGH_RST;
      zero_lo    = ZERO_LOW_RST;
      shift_bits = '0;
      bits_left  = '0;
      ph         = PH_IDLE;
      ticks_left = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      settings++;
      case (idx)
        REG_COLOR_ORDER: order   = value[2:0];
        REG_ONE_HIGH:    one_hi  = value;
        REG_ONE_LOW:     one_lo  = value;
        REG_ZERO_HIGH:   zero_hi = value;
        REG_ZERO_LOW:    zero_lo = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] cap_len(logic [7:0] v);
      return (v > CNT_MAX) ? 8'(CNT_MAX) : v;
    endfunction

    function logic [7:0] high_len();
      return cap_len(shift_bits[FRAME_BITS-1] ? one_hi : zero_hi);
    endfunction

    function logic [7:0] low_len();
      return cap_len(shift_bits[FRAME_BITS-1] ? one_lo : zero_lo);
    endfunction

    function logic [FRAME_BITS-1:0] byte_order(logic [FRAME_BITS-1:0] c);
      logic [7:0] r, g, b;
      r = c[23:16];
      g = c[15:8];
      b = c[7:0];
      case (order)
        ORDER_RGB: return {r, g, b};
        ORDER_BGR: return {b, g, r};
        ORDER_BRG: return {b, r, g};
        ORDER_RBG: return {r, b, g};
        ORDER_GBR: return {g, b, r};
        default:   return {g, r, b};
      endcase
    endfunction

    // skip bits with no high and no low time; true once the frame is over
    function bit start_bit();
      while (bits_left != 0) begin
        if (high_len() != 0) begin
          ph = PH_HIGH;
          ticks_left = high_len();
          return 1'b0;
        end
        if (low_len() != 0) begin
          ph = PH_LOW;
          ticks_left = low_len();
          return 1'b0;
        end
        shift_bits = shift_bits << 1;
        bits_left--;
      end
      ph = PH_IDLE;
      ticks_left = '0;
      return 1'b1;
    endfunction

    function bit end_bit();
      shift_bits = shift_bits << 1;
      if (bits_left != 0) bits_left--;
      return start_bit();
    endfunction

    function void note_item(logic cmd, logic [FRAME_BITS-1:0] color);
      led_result_t r;
      r = '0;
      if (cmd == CMD_LOAD) begin
        loads++;
        r.line_level = (ph == PH_HIGH);
        if (ph != PH_IDLE) begin
          r.load_rejected = 1'b1;
          rejects++;
        end else begin
          shift_bits = byte_order(color);
          bits_left = 5'(FRAME_BITS);
          r.frame_done = start_bit();
        end
      end else begin
        ticks++;
        if (ph != PH_IDLE) begin
          r.line_level = (ph == PH_HIGH);
          if (ticks_left != 0) ticks_left--;
          if (ticks_left == 0) begin
            if (ph == PH_HIGH && low_len() != 0) begin
              ph = PH_LOW;
              ticks_left = low_len();
            end else begin
              r.frame_done = end_bit();
            end
          end
        end
      end
      r.busy = (ph != PH_IDLE);
      if (r.frame_done) frames++;
      line_q.push_back(r);
    endfunction

    function void report(string what, logic [7:0] exp_v, logic [7:0] got_v);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    endfunction

    function void check_result(logic [7:0] data);
      led_result_t exp_r, got_r;
      got_r = led_result_t'(data);
      if (line_q.size() == 0) begin
        report("result with no transaction outstanding", 8'h00, data);
        return;
      end
      exp_r = line_q.pop_front();
      if (got_r.line_level !== exp_r.line_level)
        report("line_level", 8'(exp_r.line_level), 8'(got_r.line_level));
      if (got_r.busy !== exp_r.busy)
        report("busy_res", 8'(exp_r.busy), 8'(got_r.busy));
      if (got_r.frame_done !== exp_r.frame_done)
        report("frame_done", 8'(exp_r.frame_done), 8'(got_r.frame_done));
      if (got_r.load_rejected !== exp_r.load_rejected)
        report("load_rejected", 8'(exp_r.load_rejected), 8'(got_r.load_rejected));
      if (got_r.pad !== exp_r.pad)
        report("tdata padding", 8'(exp_r.pad), 8'(got_r.pad));
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function int unsigned pending();
      return line_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [23:0]          in_tdata;   // [23:0] colour
  logic [0:0]           in_tuser;   // [0] cmd
  logic                 out_tvalid;
  logic                 out_tready;
  logic [7:0]           out_tdata;  // [0] line_level, [1] busy_res,
                                    // [2] frame_done, [3] load_rejected
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  bit                   hold_off_req = 1'b0;

  led_frame_scoreboard sb;

  rgb_led_pulse_width_serializer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [7:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 8'($urandom_range(0, 2));
    if (r < 95) return 8'($urandom_range(3, 8));
    return 8'($urandom_range(9, 20));
  endfunction

  task automatic send_item(input logic cmd, input logic [23:0] color, input int unsigned gap);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= color;
    do @(posedge clk); while (!in_tready);
    sb.note_item(cmd, color);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // tick out any frame in flight, then wait for every result
  task automatic drain();
    while (sb.busy()) send_item(CMD_TICK, 24'($urandom()), pick_gap());
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    int unsigned run, stall;
    bit          held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_tready <= 1'b1;
      run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 4) : $urandom_range(20, 80);
      while (run > 0 && !(hold_off_req && !held)) begin
        @(posedge clk);
        run--;
      end
      stall = pick_gap();
      if (stall > 0) out_tready <= 1'b0;
      while (stall > 0 && !(hold_off_req && !held)) begin
        @(posedge clk);
        stall--;
      end
    end
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    bit         is_load;
    bit         steady;
    logic [2:0] ord;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_LOAD;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_COLOR_ORDER;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset timing and order: idle tick, a load, a refused load
    send_item(CMD_TICK, 24'h5A5A5A, 0);
    send_item(CMD_LOAD, 24'hFF00A5, 0);
    send_item(CMD_LOAD, 24'h123456, 1);
    repeat (6) send_item(CMD_TICK, 24'($urandom()), 0);
    drain();

    // no time on any bit: frame ends on the load
    write_reg(REG_ONE_HIGH, 8'd0);
    write_reg(REG_ONE_LOW, 8'd0);
    write_reg(REG_ZERO_HIGH, 8'd0);
    write_reg(REG_ZERO_LOW, 8'd0);
    send_item(CMD_LOAD, 24'hFFFFFF, 0);
    send_item(CMD_LOAD, 24'h000000, 0);
    send_item(CMD_TICK, 24'hFFFFFF, 0);
    drain();

    // undefined order codes, one bits high only, zero bits low only
    write_reg(REG_COLOR_ORDER, 8'hFE);
    write_reg(REG_ONE_HIGH, 8'd1);
    write_reg(REG_ZERO_LOW, 8'd1);
    send_item(CMD_LOAD, 24'hC3A50F, 0);
    drain();
    write_reg(REG_COLOR_ORDER, 8'h07);
    send_item(CMD_LOAD, 24'h0F1E2D, 0);
    drain();

    // longest phases on a single one bit
    write_reg(REG_COLOR_ORDER, 8'(ORDER_RGB));
    write_reg(REG_ONE_HIGH, 8'hFF);
    write_reg(REG_ONE_LOW, 8'hFF);
    write_reg(REG_ZERO_LOW, 8'd0);
    send_item(CMD_LOAD, 24'h000001, 0);
    drain();

    for (int p = 0; p < NUM_SETTINGS; p++) begin
      ord = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      write_reg(REG_COLOR_ORDER, {5'($urandom()), ord});
      write_reg(REG_ONE_HIGH, pick_len());
      write_reg(REG_ONE_LOW, pick_len());
      write_reg(REG_ZERO_HIGH, pick_len());
      write_reg(REG_ZERO_LOW, pick_len());
      if (p == 0) write_reg(UNUSED_REG, 8'($urandom()));
      steady = ($urandom_range(0, 3) == 0);
      if (p == 1) begin
        hold_off_req = 1'b1;
        steady = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_SET; n++) begin
        is_load = sb.busy() ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 1) == 0);
        send_item(is_load ? CMD_LOAD : CMD_TICK, 24'($urandom()), steady ? 0 : pick_gap());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d colour loads (%0d refused while busy), %0d ticks, %0d frames",
             sb.loads, sb.rejects, sb.ticks, sb.frames);
    $display("across %0d register writes, all eight order codes and 0 to 255 tick phases",
             sb.settings);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
